// ===== design/mavl_pkg.sv =====
// ----------------------------------------------------------------------------
// Moving-average level alarm package
// Shared types and constants for the level alarm block.
// ----------------------------------------------------------------------------
`default_nettype none

package mavl_pkg;

    localparam int CFG_W   = 12;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W   = 12;
    localparam int CLASS_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GOOD_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS = 2'd2;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] GOOD_LIMIT_RST = 12'd1000;
    localparam logic [CFG_W-1:0] WARN_LIMIT_RST = 12'd2000;
    localparam logic [CFG_W-1:0] HYSTERESIS_RST = 12'd100;

    // Level grades
    localparam logic [CLASS_W-1:0] CLASS_GOOD = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_WARN = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_BAD  = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] good_limit;
        logic [CFG_W-1:0] warn_limit;
        logic [CFG_W-1:0] hysteresis;
    } cfg_regs_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ===== design/mavl_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mavl_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 8
) (
    input  wire logic                                     clk,
    input  wire logic                                     wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                         wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/mavl_cfg.sv =====
// ----------------------------------------------------------------------------
// Level alarm configuration registers
// Decodes writes on the configuration port into the three limit registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mavl_cfg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wen,
    input  wire logic [mavl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mavl_pkg::CFG_W-1:0] cfg_wdata,
    output mavl_pkg::cfg_regs_t             cfg
);

    import mavl_pkg::*;

    cfg_regs_t cfg_reg;
    cfg_regs_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            case (cfg_index)
                CFG_GOOD_LIMIT: cfg_next.good_limit = cfg_wdata;
                CFG_WARN_LIMIT: cfg_next.warn_limit = cfg_wdata;
                CFG_HYSTERESIS: cfg_next.hysteresis = cfg_wdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.good_limit <= GOOD_LIMIT_RST;
            cfg_reg.warn_limit <= WARN_LIMIT_RST;
            cfg_reg.hysteresis <= HYSTERESIS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== design/mavl_div.sv =====
// ----------------------------------------------------------------------------
// Bit-serial restoring divider
// Shifts the dividend in one bit per cycle and keeps the low quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mavl_div #(
    parameter int DIVIDEND_W = 16,
    parameter int DIVISOR_W  = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [DIVIDEND_W-1:0]      dividend,
    input  wire logic [DIVISOR_W-1:0]       divisor,
    output logic                            done,
    output logic      [mavl_pkg::OUT_W-1:0] quotient
);

    import mavl_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] dvd_reg;
    logic [DIVIDEND_W-1:0] dvd_next;
    logic [DIVISOR_W-1:0]  dsr_reg;
    logic [DIVISOR_W-1:0]  dsr_next;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [OUT_W-1:0]      quo_reg;
    logic [OUT_W-1:0]      quo_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  q_bit;

    // The remainder stays below the divisor, so the shifted value fits in
    // one bit more than the divisor.
    assign rem_shift = {rem_reg, dvd_reg[DIVIDEND_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};
    assign q_bit     = (rem_shift >= {1'b0, dsr_reg});

    always_comb
    begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DIVIDEND_W-2:0], 1'b0};
            rem_next = q_bit ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            quo_next = {quo_reg[OUT_W-2:0], q_bit};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== design/moving_average_level_alarm.sv =====
// ----------------------------------------------------------------------------
// Moving-average level alarm
// Averages the last WINDOW converter samples, grades the average and keeps
// an alarm latch with hysteresis.
// ----------------------------------------------------------------------------
// Samples arrive on the s_axis stream, one transaction per sample, and each
// sample gives exactly one result transaction on the m_axis stream. While
// the window fills, the average is taken over the samples seen so far.
// After acceptance, the update state adjusts the running total while the
// ring returns the oldest sample; the bit-serial divider then forms the
// average, and the result is graded and loaded into the output register.
// The block handles one sample at a time: a new sample is taken only when
// the previous one has left the divider and reached the output register.
// A result waiting in the output register does not block the next sample;
// if the receiver stalls, the finished result of the next sample waits in
// the divider until the output register frees up.
// The configuration port writes a limit register; write it only while no
// sample is in flight. Reset empties the window, clears the alarm and
// restores the limits to 1000, 2000 and 100.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_level_alarm #(
    parameter int WINDOW      = 8,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // s_axis_tdata: sample [SAMPLE_BITS-1:0], zero padding above
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [((SAMPLE_BITS + 7) / 8)*8-1:0] s_axis_tdata,
    // m_axis_tdata: filtered_value [11:0], level_class [13:12],
    // alarm_active [14], zero padding [15]
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic      [15:0]                          m_axis_tdata,
    input  wire logic                                 cfg_wen,
    input  wire logic [mavl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [mavl_pkg::CFG_W-1:0]           cfg_wdata
);

    import mavl_pkg::*;

    localparam int FILL_W  = $clog2(WINDOW + 1);
    localparam int POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int TOTAL_W = SAMPLE_BITS + FILL_W;

    cfg_regs_t cfg;

    state_t state_reg;
    state_t state_next;

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] sample_next;
    logic [TOTAL_W-1:0]     total_reg;
    logic [TOTAL_W-1:0]     total_next;
    logic [FILL_W-1:0]      fill_reg;
    logic [FILL_W-1:0]      fill_next;
    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       pos_next;
    logic                   alarm_reg;
    logic                   alarm_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [15:0]            out_data_reg;
    logic [15:0]            out_data_next;

    logic                   in_accept;
    logic                   ring_full;
    logic [SAMPLE_BITS-1:0] oldest;
    logic                   ring_wen;
    logic                   div_start;
    logic                   div_done;
    logic [OUT_W-1:0]       quotient;
    logic                   emit_ok;
    logic [CLASS_W-1:0]     grade;
    logic                   alarm_new;

    mavl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mavl_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wen),
        .wr_addr (pos_reg),
        .wr_data (sample_reg),
        .rd_addr (pos_reg),
        .rd_data (oldest)
    );

    mavl_div #(
        .DIVIDEND_W (TOTAL_W),
        .DIVISOR_W  (FILL_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total_next),
        .divisor  (fill_next),
        .done     (div_done),
        .quotient (quotient)
    );

    assign ring_full = (fill_reg == FILL_W'(WINDOW));
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign emit_ok   = !out_valid_reg || m_axis_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        ring_wen      = 1'b0;
        div_start     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_UPDATE:
            begin
                ring_wen  = 1'b1;
                div_start = 1'b1;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Window bookkeeping; the ring read data holds the oldest sample while
    // in the update state.
    always_comb
    begin
        sample_next = sample_reg;
        total_next  = total_reg;
        fill_next   = fill_reg;
        pos_next    = pos_reg;
        if (in_accept)
        begin
            sample_next = s_axis_tdata[SAMPLE_BITS-1:0];
        end
        if (state_reg == ST_UPDATE)
        begin
            if (ring_full)
            begin
                total_next = total_reg - TOTAL_W'(oldest) + TOTAL_W'(sample_reg);
            end
            else
            begin
                total_next = total_reg + TOTAL_W'(sample_reg);
                fill_next  = fill_reg + FILL_W'(1);
            end
            if (pos_reg == POS_W'(WINDOW - 1))
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    // Grading and alarm latch
    always_comb
    begin
        if (quotient < cfg.good_limit)
        begin
            grade = CLASS_GOOD;
        end
        else if (quotient <= cfg.warn_limit)
        begin
            grade = CLASS_WARN;
        end
        else
        begin
            grade = CLASS_BAD;
        end

        alarm_new = alarm_reg;
        if (!alarm_reg)
        begin
            if (quotient > cfg.warn_limit)
            begin
                alarm_new = 1'b1;
            end
        end
        else if ((cfg.hysteresis <= cfg.warn_limit) &&
                 (quotient <= (cfg.warn_limit - cfg.hysteresis)))
        begin
            alarm_new = 1'b0;
        end
    end

    always_comb
    begin
        alarm_next     = alarm_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == ST_EMIT) && emit_ok)
        begin
            alarm_next     = alarm_new;
            out_valid_next = 1'b1;
            out_data_next  = {1'b0, alarm_new, grade, quotient};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            fill_reg      <= '0;
            pos_reg       <= '0;
            alarm_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            fill_reg      <= fill_next;
            pos_reg       <= pos_next;
            alarm_reg     <= alarm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire
